// File: design/assert_macros.svh
// Assertion helpers used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define AFC_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: implication check failed");
// Next-cycle implication
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");
`else
`define AFC_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// File: design/afc_pkg.sv
package afc_pkg;

    // Fixed beat field widths
    localparam int FIELD_W   = 32;
    localparam int IDX_W     = 3;
    localparam int FRAC_BITS = 16;

    // Function codes on the input channel
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_LOAD,
        KIND_TEST
    } t_kind;

    // Control part of a queued entry
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] plane_index;
        logic             last_corner;
    } t_entry_ctl;

    // Back-end status seen at the top level
    typedef struct packed {
        logic s2_valid;
        logic flags_all_set;
    } t_back_stat;

endpackage

// File: design/afc_in_if.sv
interface afc_in_if import afc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [IDX_W-1:0]          plane_index;
    logic signed [FIELD_W-1:0] coef_a;
    logic signed [FIELD_W-1:0] coef_b;
    logic signed [FIELD_W-1:0] coef_c;
    logic signed [FIELD_W-1:0] coef_d;
    logic signed [FIELD_W-1:0] corner_x;
    logic signed [FIELD_W-1:0] corner_y;
    logic signed [FIELD_W-1:0] corner_z;
    logic                      last_corner;

    modport source (
        output valid, func, plane_index, coef_a, coef_b, coef_c, coef_d,
               corner_x, corner_y, corner_z, last_corner,
        input  ready
    );
    modport sink (
        input  valid, func, plane_index, coef_a, coef_b, coef_c, coef_d,
               corner_x, corner_y, corner_z, last_corner,
        output ready
    );
endinterface

// File: design/afc_out_if.sv
interface afc_out_if import afc_pkg::*; ();
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

// File: design/afc_front.sv
module afc_front import afc_pkg::*; #(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    afc_in_if.sink                           i_in,
    output logic                             o_q_valid,
    output t_entry_ctl                       o_q_ctl,
    output logic [3:0][COORD_WIDTH-1:0]      o_q_data,
    input  logic                             i_q_ready
);

    t_entry_ctl                  r_ctl_mem  [QUEUE_DEPTH];
    logic [3:0][COORD_WIDTH-1:0] r_data_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]           r_wr_ptr;
    logic [QPTR_W-1:0]           r_rd_ptr;
    logic [QCNT_W-1:0]           r_count;
    logic [QCNT_W-1:0]           n_count;

    logic       in_beat;
    logic       is_test;
    logic       drop_load;
    logic       push;
    logic       pop;
    t_entry_ctl push_ctl;
    logic [3:0][COORD_WIDTH-1:0] push_data;

    // Classify the incoming beat; loads to a missing plane are dropped here
    assign i_in.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign in_beat    = i_in.valid && i_in.ready;
    assign is_test    = (i_in.func == FUNC_TEST);
    assign drop_load  = (i_in.func == FUNC_LOAD) && (int'(i_in.plane_index) >= NUM_PLANES);
    assign push       = in_beat && !drop_load;
    assign pop        = o_q_valid && i_q_ready;

    always_comb begin
        push_ctl.kind        = is_test ? KIND_TEST : KIND_LOAD;
        push_ctl.plane_index = i_in.plane_index;
        push_ctl.last_corner = i_in.last_corner;
        if (is_test) begin
            push_data[0] = i_in.corner_x[COORD_WIDTH-1:0];
            push_data[1] = i_in.corner_y[COORD_WIDTH-1:0];
            push_data[2] = i_in.corner_z[COORD_WIDTH-1:0];
            push_data[3] = '0;
        end else begin
            push_data[0] = i_in.coef_a[COORD_WIDTH-1:0];
            push_data[1] = i_in.coef_b[COORD_WIDTH-1:0];
            push_data[2] = i_in.coef_c[COORD_WIDTH-1:0];
            push_data[3] = i_in.coef_d[COORD_WIDTH-1:0];
        end
    end

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // Queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ctl_mem[r_wr_ptr]  <= push_ctl;
            r_data_mem[r_wr_ptr] <= push_data;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_ctl   = r_ctl_mem[r_rd_ptr];
    assign o_q_data  = r_data_mem[r_rd_ptr];

endmodule

// File: design/afc_back.sv
module afc_back import afc_pkg::*; #(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  t_entry_ctl                  i_q_ctl,
    input  logic [3:0][COORD_WIDTH-1:0] i_q_data,
    output logic                        o_q_ready,
    afc_out_if.source                   o_out,
    output t_back_stat                  o_stat
);

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int SUM_W  = 2 * COORD_WIDTH + 2;

    // Plane store: a, b, c, d per plane
    logic [3:0][COORD_WIDTH-1:0] r_plane [NUM_PLANES];

    // Stage 1: products
    logic                          r_s1_valid;
    logic                          r_s1_last;
    logic signed [PROD_W-1:0]      r_s1_pa [NUM_PLANES];
    logic signed [PROD_W-1:0]      r_s1_pb [NUM_PLANES];
    logic signed [PROD_W-1:0]      r_s1_pc [NUM_PLANES];
    logic signed [COORD_WIDTH-1:0] r_s1_d  [NUM_PLANES];

    // Stage 2: partial sums
    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic signed [SUM_W-1:0]  r_s2_ab [NUM_PLANES];
    logic signed [SUM_W-1:0]  r_s2_cd [NUM_PLANES];

    // Behind flags and result register
    logic [NUM_PLANES-1:0] r_flags;
    logic [NUM_PLANES-1:0] n_flags;
    logic                  r_out_valid;
    logic                  r_visible;

    logic                      advance;
    logic                      pop;
    logic                      pop_test;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic signed [SUM_W-1:0]   total [NUM_PLANES];
    logic [NUM_PLANES-1:0]     now_behind;
    logic [NUM_PLANES-1:0]     flags_and_now;

    // Whole back pipeline moves when the result slot is free or being taken
    assign advance   = !r_out_valid || o_out.ready;
    assign o_q_ready = advance;
    assign pop       = i_q_valid && advance;
    assign pop_test  = pop && (i_q_ctl.kind == KIND_TEST);

    assign cx = i_q_data[0];
    assign cy = i_q_data[1];
    assign cz = i_q_data[2];

    // Plane loads are applied in order with the corner stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
        end else if (pop && (i_q_ctl.kind == KIND_LOAD)) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (int'(i_q_ctl.plane_index) == p) begin
                    r_plane[p] <= i_q_data;
                end
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= pop_test;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 1: three multipliers per plane, side by side
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_last <= i_q_ctl.last_corner;
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_s1_pa[p] <= $signed(r_plane[p][0]) * cx;
                r_s1_pb[p] <= $signed(r_plane[p][1]) * cy;
                r_s1_pc[p] <= $signed(r_plane[p][2]) * cz;
                r_s1_d[p]  <= $signed(r_plane[p][3]);
            end
        end
    end

    // Stage 2: pairwise sums, d scaled to Q32.32
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_last <= r_s1_last;
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_s2_ab[p] <= SUM_W'(r_s1_pa[p]) + SUM_W'(r_s1_pb[p]);
                r_s2_cd[p] <= SUM_W'(r_s1_pc[p]) + (SUM_W'(r_s1_d[p]) <<< FRAC_BITS);
            end
        end
    end

    // Final sum; sign bit says behind
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            total[p]      = r_s2_ab[p] + r_s2_cd[p];
            now_behind[p] = total[p][SUM_W-1];
        end
    end

    assign flags_and_now = r_flags & now_behind;

    always_comb begin
        n_flags = r_flags;
        if (r_s2_valid) begin
            n_flags = r_s2_last ? '1 : flags_and_now;
        end
    end

    // Flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '1;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_flags     <= n_flags;
            r_out_valid <= r_s2_valid && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_visible <= (flags_and_now == '0);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.visible        = r_visible;
    assign o_stat.s2_valid      = r_s2_valid;
    assign o_stat.flags_all_set = &r_flags;

endmodule

// File: design/aabb_frustum_cull_test.sv
// Frustum cull test for axis-aligned boxes.
// Input channel i_in: func=0 loads plane plane_index with coef_a..coef_d
// (signed Q16.16); loads to a plane index past the plane count are dropped.
// func=1 brings one box corner (corner_x/y/z); last_corner marks the final
// corner of the box. Each corner is tested against every plane in parallel.
// Output channel o_out: one beat per box, on its last corner; visible=0 when
// some plane has every corner of the box strictly behind it.
// Throughput: one input beat per cycle, loads and corners alike, while o_out
// is not stalled. A corner passes the queue (written at the accept edge),
// then the product, partial-sum and result registers before its result.
// Plane loads take effect in stream order, for corners that follow them.
// A stalled o_out freezes the back pipeline; the 4-entry input queue keeps
// accepting until full, then i_in.ready drops.
// Reset: planes clear to zero (never cull), running flags set, queue and
// result slot empty.
`include "assert_macros.svh"

module aabb_frustum_cull_test import afc_pkg::*; #(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afc_in_if.sink    i_in,
    afc_out_if.source o_out
);

    logic                        q_valid;
    logic                        q_ready;
    t_entry_ctl                  q_ctl;
    logic [3:0][COORD_WIDTH-1:0] q_data;
    t_back_stat                  back_stat;

    afc_front #(
        .NUM_PLANES (NUM_PLANES),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_q_valid(q_valid),
        .o_q_ctl  (q_ctl),
        .o_q_data (q_data),
        .i_q_ready(q_ready)
    );

    afc_back #(
        .NUM_PLANES (NUM_PLANES),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_ctl  (q_ctl),
        .i_q_data (q_data),
        .o_q_ready(q_ready),
        .o_out    (o_out),
        .o_stat   (back_stat)
    );

    // A queued entry the back end cannot take stays queued
    `AFC_ASSERT_NEXT(a_queue_hold, i_clk, i_rst_n, q_valid && !q_ready, q_valid)
    // A new result comes only out of the last pipeline stage
    `AFC_ASSERT_IMPL(a_out_from_pipe, i_clk, i_rst_n, o_out.valid && !$past(o_out.valid), $past(back_stat.s2_valid))
    // Reporting a box re-arms the running flags
    `AFC_ASSERT_IMPL(a_flags_rearm, i_clk, i_rst_n, o_out.valid && !$past(o_out.valid), back_stat.flags_all_set)

endmodule

// File: test/tb_aabb_frustum_cull_test.sv
module tb_aabb_frustum_cull_test import afc_pkg::*; ();

    localparam int PLANES      = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;
    localparam int ITEM_TARGET = 1750;

    localparam logic signed [FIELD_W-1:0] C_MAX = 32'sh7fff_ffff;
    localparam logic signed [FIELD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] C_ONE = 32'sd65536;

    // One input beat, as seen on the channel
    typedef struct {
        logic                      func;
        logic [IDX_W-1:0]          plane_index;
        logic signed [FIELD_W-1:0] coef_a;
        logic signed [FIELD_W-1:0] coef_b;
        logic signed [FIELD_W-1:0] coef_c;
        logic signed [FIELD_W-1:0] coef_d;
        logic signed [FIELD_W-1:0] corner_x;
        logic signed [FIELD_W-1:0] corner_y;
        logic signed [FIELD_W-1:0] corner_z;
        logic                      last_corner;
    } t_cull_beat;

    // Plane store, running behind flags and the visible bits still owed
    class cull_scoreboard;
        logic signed [FIELD_W-1:0] plane_coef [PLANES][4];
        bit [PLANES-1:0]           behind_all;
        bit                        visible_q [$];
        int                        errors;

        function new();
            for (int p = 0; p < PLANES; p++)
                for (int k = 0; k < 4; k++)
                    plane_coef[p][k] = '0;
            behind_all = '1;
            errors     = 0;
        endfunction

        // Exact a*x + b*y + c*z + d*2^16, sign of the wide sum
        function bit corner_behind(int p, logic signed [FIELD_W-1:0] x,
                                   logic signed [FIELD_W-1:0] y,
                                   logic signed [FIELD_W-1:0] z);
            logic signed [69:0] wa, wb, wc, wd, wx, wy, wz, acc;
            wa  = plane_coef[p][0];
            wb  = plane_coef[p][1];
            wc  = plane_coef[p][2];
            wd  = plane_coef[p][3];
            wx  = x;
            wy  = y;
            wz  = z;
            acc = wa * wx + wb * wy + wc * wz + wd * 70'sd65536;
            return acc[69];
        endfunction

        function void note_beat(t_cull_beat b);
            bit [PLANES-1:0] behind_now;
            if (b.func == FUNC_LOAD) begin
                // out-of-range plane loads are dropped
                if (b.plane_index < PLANES) begin
                    plane_coef[b.plane_index][0] = b.coef_a;
                    plane_coef[b.plane_index][1] = b.coef_b;
                    plane_coef[b.plane_index][2] = b.coef_c;
                    plane_coef[b.plane_index][3] = b.coef_d;
                end
                return;
            end
            for (int p = 0; p < PLANES; p++)
                behind_now[p] = corner_behind(p, b.corner_x, b.corner_y, b.corner_z);
            behind_all &= behind_now;
            if (b.last_corner) begin
                visible_q.push_back(behind_all == '0);
                behind_all = '1;
            end
        endfunction

        function void check_visible(logic got);
            bit want;
            if (visible_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual visible=%b",
                         $time, got);
                errors++;
                return;
            end
            want = visible_q.pop_front();
            if (got !== want) begin
                $display("%0t: visible mismatch, expected %b, actual %b", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return visible_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    afc_in_if  in_if ();
    afc_out_if out_if ();

    aabb_frustum_cull_test #(
        .NUM_PLANES  (PLANES),
        .COORD_WIDTH (FIELD_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    cull_scoreboard sb;
    int  cycle_count  = 0;
    int  items_sent   = 0;
    int  burst_left   = 0;
    bit  no_gaps      = 1'b0;
    bit  rx_hold_req  = 1'b0;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_aabb_frustum_cull_test: done, errors");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_visible(out_if.visible);
    end

    // Receiver: randomly chosen stall patterns, long hold-off on request
    initial begin : receiver
        int mode;
        int mode_age;
        int phase;
        mode     = 0;
        mode_age = 0;
        phase    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (++mode_age == 64) begin
                mode_age = 0;
                mode     = $urandom_range(0, 3);
            end
            phase = (phase == 2) ? 0 : phase + 1;
            case (mode)
                0: out_if.ready = 1'b1;
                1: out_if.ready = 1'($urandom_range(0, 1));
                2: out_if.ready = ($urandom_range(0, 3) == 0);
                default: out_if.ready = (phase == 0);
            endcase
        end
    end

    function automatic int rand_span(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic t_cull_beat make_load(int idx, logic signed [FIELD_W-1:0] a,
                                             logic signed [FIELD_W-1:0] b,
                                             logic signed [FIELD_W-1:0] c,
                                             logic signed [FIELD_W-1:0] d);
        t_cull_beat t;
        t.func        = FUNC_LOAD;
        t.plane_index = IDX_W'(idx);
        t.coef_a      = a;
        t.coef_b      = b;
        t.coef_c      = c;
        t.coef_d      = d;
        // corner fields and last flag are don't-care on a load
        t.corner_x    = $urandom();
        t.corner_y    = $urandom();
        t.corner_z    = $urandom();
        t.last_corner = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic t_cull_beat make_corner(logic signed [FIELD_W-1:0] x,
                                               logic signed [FIELD_W-1:0] y,
                                               logic signed [FIELD_W-1:0] z, bit last);
        t_cull_beat t;
        t.func        = FUNC_TEST;
        t.plane_index = IDX_W'($urandom_range(0, 7));
        t.coef_a      = $urandom();
        t.coef_b      = $urandom();
        t.coef_c      = $urandom();
        t.coef_d      = $urandom();
        t.corner_x    = x;
        t.corner_y    = y;
        t.corner_z    = z;
        t.last_corner = last;
        return t;
    endfunction

    // Drive one beat at the falling edge, wait for the handshake
    task automatic send_beat(t_cull_beat b);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 6);
            if (no_gaps)
                gap = 0;
            if (gap != 0) begin
                in_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_if.func        = b.func;
        in_if.plane_index = b.plane_index;
        in_if.coef_a      = b.coef_a;
        in_if.coef_b      = b.coef_b;
        in_if.coef_c      = b.coef_c;
        in_if.coef_d      = b.coef_d;
        in_if.corner_x    = b.corner_x;
        in_if.corner_y    = b.corner_y;
        in_if.corner_z    = b.corner_z;
        in_if.last_corner = b.last_corner;
        in_if.valid       = 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_beat(b);
        burst_left--;
        if (!(b.func == FUNC_LOAD && b.plane_index >= PLANES))
            items_sent++;
    endtask

    // Stop offering and wait for every owed result
    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        burst_left  = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Load one plane with a randomly chosen flavor
    task automatic send_plane(int idx);
        logic signed [FIELD_W-1:0] a, b, c, d;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 1) begin
            a = $urandom(); b = $urandom(); c = $urandom(); d = $urandom();
        end else if (kind <= 6) begin
            // plane with the origin in front of it
            a = rand_span(65536); b = rand_span(65536); c = rand_span(65536);
            d = $urandom_range(1 << 16, 1 << 24);
        end else if (kind == 7) begin
            a = rand_span(65536); b = rand_span(65536); c = rand_span(65536);
            d = -int'($urandom_range(0, 1 << 22));
        end else if (kind == 8) begin
            a = '0; b = '0; c = '0; d = '0;
        end else begin
            a = rand_span(1 << 18); b = rand_span(1 << 18); c = rand_span(1 << 18);
            d = rand_span(1 << 22);
        end
        send_beat(make_load(idx, a, b, c, d));
    endtask

    // Stream one box; n corners, last one flagged, optional plane loads ahead of any corner
    task automatic send_box(int n, bit near_box, bit mid_loads);
        logic signed [FIELD_W-1:0] cx, cy, cz, ex, ey, ez, x, y, z;
        int sel;
        if (near_box) begin
            cx = rand_span(1 << 20); cy = rand_span(1 << 20); cz = rand_span(1 << 20);
        end else begin
            cx = $urandom(); cy = $urandom(); cz = $urandom();
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            ex = '0; ey = '0; ez = '0;
        end else if (sel <= 7 || near_box) begin
            ex = $urandom_range(0, 1 << 18);
            ey = $urandom_range(0, 1 << 18);
            ez = $urandom_range(0, 1 << 18);
        end else begin
            ex = $urandom(); ey = $urandom(); ez = $urandom();
        end
        for (int i = 0; i < n; i++) begin
            x = (i % 2 != 0)       ? cx + ex : cx - ex;
            y = ((i / 2) % 2 != 0) ? cy + ey : cy - ey;
            z = ((i / 4) % 2 != 0) ? cz + ez : cz - ez;
            if (mid_loads && $urandom_range(0, 19) == 0)
                send_plane($urandom_range(0, PLANES - 1));
            send_beat(make_corner(x, y, z, i == n - 1));
        end
    endtask

    // Stimulus
    initial begin : stimulus
        int  pick;
        int  n;
        bit  held;
        bit  drained;
        sb = new();
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.func        = FUNC_LOAD;
        in_if.plane_index = '0;
        in_if.coef_a      = '0;
        in_if.coef_b      = '0;
        in_if.coef_c      = '0;
        in_if.coef_d      = '0;
        in_if.corner_x    = '0;
        in_if.corner_y    = '0;
        in_if.corner_z    = '0;
        in_if.last_corner = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // no plane loaded yet: nothing can cull
        send_beat(make_corner('0, '0, '0, 1'b1));
        send_beat(make_corner(C_MAX, C_MIN, C_MAX, 1'b0));
        send_beat(make_corner(C_MIN, C_MAX, C_MIN, 1'b1));
        // x >= 0 half space, plus dropped loads past the plane count
        send_beat(make_load(0, C_ONE, '0, '0, '0));
        send_beat(make_load(6, C_MIN, C_MIN, C_MIN, C_MIN));
        send_beat(make_load(7, -C_ONE, '0, '0, C_MIN));
        send_beat(make_corner(-32'sd1, '0, '0, 1'b1));
        // exactly on the plane is not behind
        send_beat(make_corner('0, C_MAX, C_MIN, 1'b1));
        send_beat(make_corner(-C_ONE, '0, '0, 1'b0));
        send_beat(make_corner(C_ONE, '0, '0, 1'b1));
        // extreme coefficients
        send_beat(make_load(5, C_MAX, C_MIN, C_MAX, C_MIN));
        send_beat(make_load(1, C_MIN, C_MIN, C_MIN, C_MIN));
        send_beat(make_load(2, C_MAX, C_MAX, C_MAX, C_MAX));
        send_beat(make_corner(C_MIN, C_MIN, C_MIN, 1'b0));
        send_beat(make_corner(C_MAX, C_MAX, C_MAX, 1'b1));
        send_beat(make_corner(C_MIN, '0, '0, 1'b0));
        send_beat(make_corner(-32'sd1, C_MIN, C_MAX, 1'b0));
        send_beat(make_corner(C_MIN, C_MAX, C_MAX, 1'b1));
        // z >= 1 and y <= 0 half spaces
        send_beat(make_load(3, '0, '0, C_ONE, -C_ONE));
        send_beat(make_load(4, '0, -C_ONE, '0, '0));
        send_beat(make_corner(C_ONE, -C_ONE, '0, 1'b1));
        send_beat(make_corner(C_ONE, C_ONE, C_ONE, 1'b1));
        send_beat(make_load(0, '0, '0, '0, '0));
        send_beat(make_load(1, '0, '0, '0, '0));
        drain_results();

        // Random boxes with occasional plane reloads and noise
        held    = 1'b0;
        drained = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            if (!held && items_sent >= 600) begin
                // receiver holds off while corners keep coming
                held        = 1'b1;
                no_gaps     = 1'b1;
                rx_hold_req = 1'b1;
                repeat (5) send_box(8, 1'b1, 1'b0);
                no_gaps = 1'b0;
            end
            if (!drained && items_sent >= 1200) begin
                drained = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                n = $urandom_range(1, PLANES);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0)
                        send_plane($urandom_range(PLANES, 7));
                    else
                        send_plane($urandom_range(0, PLANES - 1));
                end
            end else if (pick < 20) begin
                send_beat(make_corner($urandom(), $urandom(), $urandom(),
                                      1'($urandom_range(0, 1))));
            end else if (pick < 24) begin
                send_beat(make_load($urandom_range(0, 7), $urandom(), $urandom(),
                                    $urandom(), $urandom()));
            end else begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 8;
                send_box(n, $urandom_range(0, 3) != 0, 1'b1);
            end
        end

        // Wait out the pipeline after the last owed result
        drain_results();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_aabb_frustum_cull_test: done, clean");
        else
            $display("tb_aabb_frustum_cull_test: done, errors");
        $finish;
    end

endmodule

// File: aabb_frustum_cull_test.f
+incdir+design
design/afc_pkg.sv
design/afc_in_if.sv
design/afc_out_if.sv
design/afc_front.sv
design/afc_back.sv
design/aabb_frustum_cull_test.sv
test/tb_aabb_frustum_cull_test.sv
